// ===== hdl/b32e_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Base32 stream encoder package
// Shared widths, constants, the queue command word and the alphabet lookup.
// ---------------------------------------------------------------------------
package b32e_pkg;

	localparam int BYTE_W      = 8;
	localparam int SYM_W       = 5;
	localparam int CHAR_W      = 7;
	localparam int BITS_W      = 4;
	localparam int LCNT_W      = 3;
	localparam int POS_W       = 3;
	localparam int NSYM        = 3;
	localparam int NSYM_W      = 2;
	localparam int IDX_W       = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] PAD_CODE = 7'd61;

	typedef struct packed {
		logic [NSYM-1:0][SYM_W-1:0] syms;
		logic [NSYM_W-1:0]          nsym;
		logic [POS_W-1:0]           npad;
		logic                       last_flag;
	} b32e_cmd_t;

	typedef struct packed {
		logic [LCNT_W-1:0] leftover_count;
		logic [POS_W-1:0]  out_position;
	} b32e_stat_t;

	function automatic logic [CHAR_W-1:0] sym_code(input logic [SYM_W-1:0] v);
		logic [CHAR_W-1:0] r;
		if (v < 5'd26) begin
			r = CHAR_W'(v) + 7'd65;
		end else begin
			r = CHAR_W'(v) + 7'd24;
		end
		return r;
	endfunction

endpackage

// ===== hdl/b32e_msg_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Message byte channel
// Carries one message byte word with its end marker under valid and ready.
// ---------------------------------------------------------------------------
interface b32e_msg_if;
	import b32e_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_value;
	logic              has_byte;
	logic              end_of_message;

	modport source (output valid, output byte_value, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input byte_value, input has_byte,
		input end_of_message, output ready);

endinterface

// ===== hdl/b32e_enc_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoded character channel
// Carries one character word with its last flag under valid and ready.
// ---------------------------------------------------------------------------
interface b32e_enc_if;
	import b32e_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);

endinterface

// ===== hdl/b32e_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Base32 encoder front end
// Accepts byte words, tracks leftover bits and output position, and turns
// each word that yields symbols or padding into a command for the back end.
// ---------------------------------------------------------------------------
module b32e_front (
	input  logic               clk,
	input  logic               arst_n,
	b32e_msg_if.sink           msg,
	output b32e_pkg::b32e_cmd_t cmd,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output b32e_pkg::b32e_stat_t stat
);
	import b32e_pkg::*;

	logic [BITS_W-1:0] bits_q;
	logic [LCNT_W-1:0] cnt_q;
	logic [POS_W-1:0]  pos_q;

	logic [BITS_W+BYTE_W-1:0] acc;
	logic                     two;
	logic [SYM_W-1:0]         c0;
	logic [SYM_W-1:0]         c1;
	logic [SYM_W-1:0]         fsym;
	logic [NSYM_W-1:0]        nb;
	logic [LCNT_W-1:0]        cnt_b;
	logic [BITS_W-1:0]        bits_b;
	logic [BITS_W:0]          mask;
	logic [POS_W-1:0]         pos_b;
	logic [POS_W-1:0]         pos_f;
	logic                     flush;
	logic                     accept;

	assign accept    = msg.valid && msg.ready;
	assign msg.ready = cmd_ready;

	always_comb begin
		acc  = {bits_q, msg.byte_value};
		two  = (cnt_q >= 3'd2);
		c0   = SYM_W'(acc >> (cnt_q + 3'd3));
		c1   = two ? SYM_W'(acc >> (cnt_q - 3'd2)) : '0;
		if (msg.has_byte) begin
			nb    = two ? 2'd2 : 2'd1;
			cnt_b = two ? (cnt_q - 3'd2) : (cnt_q + 3'd3);
			mask  = (5'd1 << cnt_b) - 5'd1;
			bits_b = acc[BITS_W-1:0] & mask[BITS_W-1:0];
		end else begin
			nb     = 2'd0;
			cnt_b  = cnt_q;
			mask   = '0;
			bits_b = bits_q;
		end
		pos_b = pos_q + POS_W'(nb);
		flush = msg.end_of_message && (cnt_b != '0);
		fsym  = SYM_W'({1'b0, bits_b} << (3'd5 - cnt_b));
		pos_f = pos_b + POS_W'(flush);

		cmd.syms[0]   = (nb != 2'd0) ? c0 : fsym;
		cmd.syms[1]   = (nb == 2'd2) ? c1 : fsym;
		cmd.syms[2]   = fsym;
		cmd.nsym      = nb + NSYM_W'(flush);
		cmd.npad      = msg.end_of_message ? (POS_W'(0) - pos_f) : '0;
		cmd.last_flag = msg.end_of_message;
	end

	assign cmd_valid = accept && ((cmd.nsym != '0) || (cmd.npad != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			cnt_q  <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (msg.end_of_message) begin
				bits_q <= '0;
				cnt_q  <= '0;
				pos_q  <= '0;
			end else begin
				bits_q <= bits_b;
				cnt_q  <= cnt_b;
				pos_q  <= pos_b;
			end
		end
	end

	assign stat.leftover_count = cnt_q;
	assign stat.out_position   = pos_q;

endmodule

// ===== hdl/b32e_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Base32 encoder command queue
// Short first-in first-out queue of commands between front and back end.
// ---------------------------------------------------------------------------
module b32e_queue #(
	parameter int DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  b32e_pkg::b32e_cmd_t in_cmd,
	input  logic                in_valid,
	output logic                in_ready,
	output b32e_pkg::b32e_cmd_t out_cmd,
	output logic                out_valid,
	input  logic                out_pop
);
	import b32e_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b32e_cmd_t          entries [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = entries[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/b32e_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Base32 encoder back end
// Steps through each command, one character word per cycle while the output
// is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module b32e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b32e_pkg::b32e_cmd_t head,
	input  logic                head_valid,
	output logic                pop,
	b32e_enc_if.source          enc
);
	import b32e_pkg::*;

	b32e_cmd_t         cur_q;
	logic              cur_valid_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic [IDX_W-1:0]  total;
	logic              advance;
	logic              fin;
	logic [SYM_W-1:0]  sym_sel;
	logic [CHAR_W-1:0] cur_char;

	always_comb begin
		total   = IDX_W'(cur_q.nsym) + IDX_W'(cur_q.npad);
		advance = cur_valid_q && (!out_valid_q || enc.ready);
		fin     = (idx_q == total - 1'b1);
		case (idx_q[NSYM_W-1:0])
			2'd0:    sym_sel = cur_q.syms[0];
			2'd1:    sym_sel = cur_q.syms[1];
			default: sym_sel = cur_q.syms[2];
		endcase
		cur_char = (idx_q < IDX_W'(cur_q.nsym)) ? sym_code(sym_sel) : PAD_CODE;
	end

	assign pop = head_valid && (!cur_valid_q || (advance && fin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance && fin) begin
				cur_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (enc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance) begin
			char_q <= cur_char;
			last_q <= cur_q.last_flag && fin;
		end
	end

	assign enc.valid     = out_valid_q;
	assign enc.char_code = char_q;
	assign enc.last_char = last_q;

endmodule

// ===== hdl/base32_stream_encoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Base32 stream encoder
// Encodes message bytes into Base32 characters with flush and padding.
// ---------------------------------------------------------------------------
// Throughput: one character per cycle from the back end's output register while
// the output is not stalled; a byte yields one or two characters, with end of message up to eight.
// A new word is taken whenever the command queue has room.
// Reset clears the leftover bits, counts, queue and output stage at once.
module base32_stream_encoder #(
	parameter int QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	b32e_msg_if.sink   msg,
	b32e_enc_if.source enc
);
	import b32e_pkg::*;

	b32e_cmd_t  front_cmd;
	logic       front_valid;
	logic       queue_ready;
	b32e_cmd_t  head_cmd;
	logic       head_valid;
	logic       head_pop;
	b32e_stat_t front_stat;

	b32e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (queue_ready),
		.stat      (front_stat)
	);

	b32e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (front_cmd),
		.in_valid  (front_valid),
		.in_ready  (queue_ready),
		.out_cmd   (head_cmd),
		.out_valid (head_valid),
		.out_pop   (head_pop)
	);

	b32e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_cmd),
		.head_valid (head_valid),
		.pop        (head_pop),
		.enc        (enc)
	);

	a_leftover_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.leftover_count <= 3'd4)
		else $error("leftover count above four");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && msg.end_of_message) |=>
		(front_stat.leftover_count == '0 && front_stat.out_position == '0))
		else $error("state not cleared after end of message");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid |-> (queue_ready && (front_cmd.nsym != '0 || front_cmd.npad != '0)))
		else $error("empty command or push into a full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

// ===== tb/base32_stream_encoder_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Base32 stream encoder testbench
// Drives message byte words through the input channel and checks every
// encoded character and its last flag against a built-in Base32 predictor.
// It runs directed messages first, then random messages under three idling
// phases, with one long output stall in the last phase and drains between phases.
// ---------------------------------------------------------------------------
module base32_stream_encoder_test;
	import b32e_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 80;
	localparam int TAIL_CYCLES   = 20;
	localparam int MAX_PER_WORD  = 8;
	localparam int PHASE_WORDS   = 75;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              has_byte;
		logic              end_of_message;
	} msg_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} enc_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              m_valid = 1'b0;
	logic [BYTE_W-1:0] m_byte = '0;
	logic              m_has = 1'b0;
	logic              m_eom = 1'b0;
	logic              r_ready = 1'b0;

	b32e_msg_if msg_ch ();
	b32e_enc_if enc_ch ();

	assign msg_ch.valid          = m_valid;
	assign msg_ch.byte_value     = m_byte;
	assign msg_ch.has_byte       = m_has;
	assign msg_ch.end_of_message = m_eom;
	assign enc_ch.ready          = r_ready;

	base32_stream_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.enc    (enc_ch)
	);

	msg_word_t pending_words[$];
	enc_char_t expected_chars[$];
	enc_char_t step_chars[$];

	logic [BITS_W-1:0] pend_bits = '0;
	logic [LCNT_W-1:0] pend_count = '0;
	logic [POS_W-1:0]  char_pos = '0;

	logic msg_fire = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_requests = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	int   error_count = 0;
	int   words_taken = 0;
	int   messages_ended = 0;
	int   chars_checked = 0;
	int   cycle_count = 0;

	initial begin
		forever begin
			#1 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [CHAR_W-1:0] to_char(input logic [SYM_W-1:0] v);
		if (v < 5'd26) begin
			return CHAR_W'(7'd65 + CHAR_W'(v));
		end
		return CHAR_W'(7'd50 + CHAR_W'(v) - 7'd26);
	endfunction

	function automatic void add_char(input logic [CHAR_W-1:0] code);
		enc_char_t c;
		if (step_chars.size() < MAX_PER_WORD) begin
			c.code = code;
			c.last = 1'b0;
			step_chars.insert(step_chars.size(), c);
			char_pos = char_pos + 3'd1;
		end
	endfunction

	// Works out the characters that one accepted word produces and queues them.
	function automatic void encode_word(input logic [BYTE_W-1:0] value, input logic has,
			input logic eom);
		logic [11:0] acc;
		logic [8:0]  flush;
		int unsigned cnt;
		enc_char_t   c;
		step_chars.delete();
		if (has) begin
			cnt = (pend_count > 3'd4) ? 4 : int'(pend_count);
			acc = {pend_bits, value};
			cnt += 8;
			while (cnt >= 5) begin
				add_char(to_char(SYM_W'(acc >> (cnt - 5))));
				cnt -= 5;
			end
			pend_count = LCNT_W'(cnt);
			pend_bits = BITS_W'(acc & ((12'd1 << cnt) - 12'd1));
		end
		if (eom) begin
			cnt = (pend_count > 3'd4) ? 4 : int'(pend_count);
			if (cnt > 0) begin
				flush = {5'd0, pend_bits} << (5 - cnt);
				add_char(to_char(flush[SYM_W-1:0]));
			end
			while (char_pos != '0 && step_chars.size() < MAX_PER_WORD) begin
				add_char(PAD_CODE);
			end
			pend_bits = '0;
			pend_count = '0;
			char_pos = '0;
		end
		foreach (step_chars[i]) begin
			c = step_chars[i];
			c.last = eom && (i == step_chars.size() - 1);
			expected_chars.insert(expected_chars.size(), c);
		end
	endfunction

	always @(posedge clk) begin
		enc_char_t want;
		msg_fire = m_valid && msg_ch.ready;
		if (msg_fire) begin
			words_taken++;
			if (m_eom) begin
				messages_ended++;
			end
			encode_word(m_byte, m_has, m_eom);
		end
		if (enc_ch.valid && r_ready) begin
			chars_checked++;
			if (expected_chars.size() == 0) begin
				error_count++;
				$display("%0t: unexpected character: expected none, actual code %0d last %0b",
					$time, enc_ch.char_code, enc_ch.last_char);
			end else begin
				want = expected_chars.pop_front();
				if (enc_ch.char_code !== want.code) begin
					error_count++;
					$display("%0t: char_code mismatch: expected %0d, actual %0d",
						$time, want.code, enc_ch.char_code);
				end
				if (enc_ch.last_char !== want.last) begin
					error_count++;
					$display("%0t: last_char mismatch: expected %0b, actual %0b",
						$time, want.last, enc_ch.last_char);
				end
			end
		end
	end

	always @(negedge clk) begin
		msg_word_t nxt;
		if (!m_valid || msg_fire) begin
			if (pending_words.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				nxt = pending_words.pop_front();
				m_valid <= 1'b1;
				m_byte <= nxt.byte_value;
				m_has <= nxt.has_byte;
				m_eom <= nxt.end_of_message;
			end else begin
				m_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			r_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			r_ready <= 1'b0;
		end else begin
			r_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	function automatic void push_word(input logic [BYTE_W-1:0] value, input logic has,
			input logic eom);
		msg_word_t w;
		w.byte_value = value;
		w.has_byte = has;
		w.end_of_message = eom;
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		case ($urandom_range(7, 0))
			0: return 8'h00;
			1: return 8'hFF;
			default: return BYTE_W'($urandom_range(255, 0));
		endcase
	endfunction

	// Queues one random message and returns the number of words that do work.
	function automatic int queue_message();
		int          len;
		int unsigned mode;
		int          count;
		count = 0;
		len = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 0);
		mode = $urandom_range(9, 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9, 0) == 0) begin
				push_word(rand_byte(), 1'b0, 1'b0);
			end
			push_word(rand_byte(), 1'b1, (i == len - 1) && (mode < 7));
			count++;
		end
		if (len == 0 || mode == 7 || mode == 8) begin
			push_word(rand_byte(), 1'b0, 1'b1);
			count++;
		end
		return count;
	endfunction

	task automatic drain();
		while (pending_words.size() > 0 || m_valid || expected_chars.size() > 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_phase(input int sidle, input int ridle, input bit hold);
		int queued;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		queued = 0;
		while (queued < PHASE_WORDS) begin
			queued += queue_message();
		end
		if (hold) begin
			hold_requests++;
		end
		drain();
	endtask

	initial begin
		send_idle_pct = 37;
		recv_idle_pct = 60;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_word(rand_byte(), 1'b0, 1'b1);
		push_word(rand_byte(), 1'b0, 1'b0);
		push_word(8'hFF, 1'b1, 1'b1);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(8'hFF, 1'b1, 1'b1);
		push_word(8'hFF, 1'b1, 1'b0);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(8'hFF, 1'b1, 1'b1);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(rand_byte(), 1'b1, 1'b0);
		push_word(rand_byte(), 1'b1, 1'b0);
		push_word(8'hFF, 1'b1, 1'b1);
		for (int i = 0; i < 5; i++) begin
			push_word(rand_byte(), 1'b1, 1'b0);
		end
		push_word(rand_byte(), 1'b0, 1'b1);
		push_word(8'h5A, 1'b1, 1'b0);
		push_word(rand_byte(), 1'b0, 1'b1);
		push_word(8'hC3, 1'b1, 1'b0);
		push_word(8'h3C, 1'b1, 1'b0);
		push_word(rand_byte(), 1'b0, 1'b0);
		push_word(rand_byte(), 1'b0, 1'b1);
		drain();

		run_phase(37, 60, 1'b0);
		run_phase(60, 37, 1'b0);
		run_phase(0, 0, 1'b1);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Encoded %0d message words (%0d messages ended) into %0d checked characters,",
			words_taken, messages_ended, chars_checked);
		$display("under three idling phases with one long output stall and drains between.");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/b32e_pkg.sv
hdl/b32e_msg_if.sv
hdl/b32e_enc_if.sv
hdl/b32e_front.sv
hdl/b32e_queue.sv
hdl/b32e_back.sv
hdl/base32_stream_encoder.sv
tb/base32_stream_encoder_test.sv
